/* rtl/bzt_pkg.sv */
// ----------------------------------------------------------------------------
// Bezier arc tessellator package
// Shared widths, constants and types for the arc sampling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bzt_pkg;

	// Coordinate format, signed Q7.16.
	localparam int COORD_W    = 24;
	localparam int FRAC_BITS  = 16;
	localparam int MAX_POINTS = 64;

	// Sample index and count widths.
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;

	// Bernstein weights scaled by m^3 stay below 2^18.
	localparam int WGT_W  = 18;
	localparam int CUBE_W = 18;
	localparam int DEN_W  = CUBE_W + 1;

	// Weighted products, sums and the rounded dividend.
	localparam int PROD_W = COORD_W + WGT_W + 1;
	localparam int SUM_W  = 44;
	localparam int QUO_W  = COORD_W;

	// Division by three: multiply by ceil(2^27 / 3) and shift right by 27.
	localparam int                 THIRD_SH = 27;
	localparam logic [25:0]        THIRD_K  = 26'd44739243;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;

	// Tag that travels beside each sample through the pipeline.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             last;
	} tag_t;

endpackage

`default_nettype wire

/* rtl/bzt_ctrl.sv */
// ----------------------------------------------------------------------------
// Bezier arc tessellator control
// Holds the sample count, builds the four control points of a request and
// issues one sample index per enabled cycle into the evaluation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bzt_ctrl
	import bzt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               cfg_we,
	input  wire logic [CNT_W-1:0]   cfg_wdata,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [143:0]       s_tdata,
	input  wire logic               drain_done,
	output point_t [3:0]            cp,
	output tag_t                    tag_s1,
	output logic [IDX_W-1:0]        u_s1,
	output logic [CUBE_W-1:0]       m3
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ABS   = 3'd1;
	localparam logic [2:0] ST_DIV3  = 3'd2;
	localparam logic [2:0] ST_LOADC = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  m_q;
	logic [11:0]       m2_q;
	logic [CUBE_W-1:0] m3_q;
	logic [IDX_W-1:0]  cnt_q;
	point_t            o_q;
	point_t            d_q;
	logic [25:0]       v_q [4];
	logic              neg_q [4];
	logic [QUO_W-1:0]  t_q [4];
	logic signed [25:0] y1_q;
	logic signed [25:0] y2_q;
	logic signed [25:0] n_c [4];
	coord_t            ymax_c;
	logic [51:0]       prod_c [4];
	logic [CNT_W-1:0]  clamp_c;

	// Clamp a 26-bit signed value into the coordinate range.
	function automatic coord_t sat26(input logic signed [25:0] v);
		coord_t r;
		if (v > 26'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -26'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign m3       = m3_q;

	// Count register, clamped into range, and the cube of m = count - 1.
	always_comb begin
		if (cfg_wdata < CNT_W'(2)) begin
			clamp_c = CNT_W'(2);
		end else if (cfg_wdata > CNT_W'(MAX_POINTS)) begin
			clamp_c = CNT_W'(MAX_POINTS);
		end else begin
			clamp_c = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q  <= IDX_W'(14);
			m2_q <= 12'd196;
			m3_q <= CUBE_W'(2744);
		end else begin
			if (cfg_we) begin
				m_q <= IDX_W'(clamp_c - CNT_W'(1));
			end
			m2_q <= 12'(m_q * m_q);
			m3_q <= CUBE_W'(m2_q * m_q);
		end
	end

	// Sums for the inner x and z values: 2a+b and a+2b.
	always_comb begin
		n_c[0] = {o_q.x[COORD_W-1], o_q.x, 1'b0} + {{2{d_q.x[COORD_W-1]}}, d_q.x};
		n_c[1] = {o_q.z[COORD_W-1], o_q.z, 1'b0} + {{2{d_q.z[COORD_W-1]}}, d_q.z};
		n_c[2] = {{2{o_q.x[COORD_W-1]}}, o_q.x} + {d_q.x[COORD_W-1], d_q.x, 1'b0};
		n_c[3] = {{2{o_q.z[COORD_W-1]}}, o_q.z} + {d_q.z[COORD_W-1], d_q.z, 1'b0};
		ymax_c = (o_q.y > d_q.y) ? o_q.y : d_q.y;
		for (int k = 0; k < 4; k++) begin
			prod_c[k] = 52'(v_q[k]) * 52'(THIRD_K);
		end
	end

	// Request payload and the control point datapath.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			o_q <= s_tdata[71:0];
			d_q <= s_tdata[143:72];
		end
		if (state_q == ST_ABS) begin
			for (int k = 0; k < 4; k++) begin
				neg_q[k] <= n_c[k][25];
				v_q[k]   <= (n_c[k][25] ? 26'(-n_c[k]) : 26'(n_c[k])) + 26'd1;
			end
			y1_q <= {{2{ymax_c[COORD_W-1]}}, ymax_c} + (26'sd1 <<< (FRAC_BITS - 2));
			y2_q <= {{2{ymax_c[COORD_W-1]}}, ymax_c} + (26'sd1 <<< (FRAC_BITS - 1));
		end
		if (state_q == ST_DIV3) begin
			for (int k = 0; k < 4; k++) begin
				t_q[k] <= prod_c[k][THIRD_SH+QUO_W-1:THIRD_SH];
			end
		end
		if (state_q == ST_LOADC) begin
			cp[0]   <= o_q;
			cp[3]   <= d_q;
			cp[1].x <= sat26(neg_q[0] ? -$signed({2'b00, t_q[0]}) : $signed({2'b00, t_q[0]}));
			cp[1].z <= sat26(neg_q[1] ? -$signed({2'b00, t_q[1]}) : $signed({2'b00, t_q[1]}));
			cp[2].x <= sat26(neg_q[2] ? -$signed({2'b00, t_q[2]}) : $signed({2'b00, t_q[2]}));
			cp[2].z <= sat26(neg_q[3] ? -$signed({2'b00, t_q[3]}) : $signed({2'b00, t_q[3]}));
			cp[1].y <= sat26(y1_q);
			cp[2].y <= sat26(y2_q);
		end
	end

	// Sequencer: load the control points, then issue one index per enabled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			tag_s1  <= '0;
		end else begin
			if (en) begin
				tag_s1.valid <= (state_q == ST_RUN);
				tag_s1.idx   <= cnt_q;
				tag_s1.last  <= (cnt_q == m_q);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					state_q <= ST_DIV3;
				end
				ST_DIV3: begin
					state_q <= ST_LOADC;
				end
				ST_LOADC: begin
					state_q <= ST_RUN;
					cnt_q   <= '0;
				end
				ST_RUN: begin
					if (en) begin
						cnt_q <= cnt_q + IDX_W'(1);
						if (cnt_q == m_q) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (drain_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Complement of the issued sample index.
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= m_q - cnt_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/bzt_eval.sv */
// ----------------------------------------------------------------------------
// Bezier arc tessellator evaluation
// Forms the Bernstein weights of a sample, weights the control points and
// sums them into a rounded unsigned dividend with a separate sign.
// ----------------------------------------------------------------------------
`default_nettype none

module bzt_eval
	import bzt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire tag_t              tag_s1,
	input  wire logic [IDX_W-1:0]  u_s1,
	input  wire point_t [3:0]      cp,
	input  wire logic [CUBE_W-1:0] m3,
	output logic                   drain_done,
	output tag_t                   tag_s7,
	output logic [SUM_W-1:0]       num_s7 [3],
	output logic                   neg_s7 [3]
);

	tag_t              tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [IDX_W-1:0]  i_s2, u_s2;
	logic [11:0]       i2_s2, u2_s2;
	logic [WGT_W-1:0]  w_s3 [4];
	logic signed [PROD_W-1:0] p_s4 [3][4];
	logic signed [SUM_W-1:0]  a_s5 [3];
	logic signed [SUM_W-1:0]  b_s5 [3];
	logic signed [SUM_W-1:0]  n_s6 [3];
	logic [WGT_W-1:0]  t1_c, t2_c;
	coord_t            c_c [3][4];

	// The last sample leaving the weight stage frees the control points.
	assign drain_done = en && tag_s3.valid && tag_s3.last;

	always_comb begin
		t1_c = WGT_W'(u2_s2 * i_s2);
		t2_c = WGT_W'(i2_s2 * u_s2);
		for (int k = 0; k < 4; k++) begin
			c_c[0][k] = cp[k].x;
			c_c[1][k] = cp[k].y;
			c_c[2][k] = cp[k].z;
		end
	end

	// Sample tags of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (en) begin
			// Squares of i and u.
			i_s2  <= tag_s1.idx;
			u_s2  <= u_s1;
			i2_s2 <= 12'(tag_s1.idx * tag_s1.idx);
			u2_s2 <= 12'(u_s1 * u_s1);
			// Weights u^3, 3iu^2, 3i^2u, i^3.
			w_s3[0] <= WGT_W'(u2_s2 * u_s2);
			w_s3[1] <= (t1_c << 1) + t1_c;
			w_s3[2] <= (t2_c << 1) + t2_c;
			w_s3[3] <= WGT_W'(i2_s2 * i_s2);
			// Weighted control coordinates.
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 4; k++) begin
					p_s4[c][k] <= PROD_W'(c_c[c][k] * $signed({1'b0, w_s3[k]}));
				end
			end
			// Pair sums.
			for (int c = 0; c < 3; c++) begin
				a_s5[c] <= SUM_W'(p_s4[c][0]) + SUM_W'(p_s4[c][1]);
				b_s5[c] <= SUM_W'(p_s4[c][2]) + SUM_W'(p_s4[c][3]);
			end
			// Full numerator.
			for (int c = 0; c < 3; c++) begin
				n_s6[c] <= a_s5[c] + b_s5[c];
			end
			// Rounded dividend 2|num| + m^3 and sign.
			for (int c = 0; c < 3; c++) begin
				neg_s7[c] <= n_s6[c][SUM_W-1];
				num_s7[c] <= ((n_s6[c][SUM_W-1] ? SUM_W'(-n_s6[c]) : SUM_W'(n_s6[c])) << 1)
					+ SUM_W'(m3);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/bzt_div.sv */
// ----------------------------------------------------------------------------
// Bezier arc tessellator divider
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing the divisor 2*m^3.
// ----------------------------------------------------------------------------
`default_nettype none

module bzt_div
	import bzt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [CUBE_W-1:0] m3,
	input  wire tag_t              tag_in,
	input  wire logic [SUM_W-1:0]  num_in [3],
	input  wire logic              neg_in [3],
	output tag_t                   tag_out,
	output logic [QUO_W-1:0]       quo_out [3],
	output logic                   neg_out [3]
);

	tag_t             tag_s [1:QUO_W];
	logic [SUM_W-1:0] rem_s [1:QUO_W][3];
	logic [QUO_W-1:0] quo_s [1:QUO_W][3];
	logic             neg_s [1:QUO_W][3];
	logic [DEN_W-1:0] den_c;

	assign den_c = {m3, 1'b0};

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		tag_t             tag_p;
		logic [SUM_W-1:0] rem_p [3];
		logic [QUO_W-1:0] quo_p [3];
		logic             neg_p [3];
		logic [SUM_W-1:0] dsh;

		assign dsh = SUM_W'(den_c) << (QUO_W - 1 - j);

		// The first stage takes the incoming word, the others the stage before.
		if (j == 0) begin : g_first
			always_comb begin
				tag_p = tag_in;
				for (int c = 0; c < 3; c++) begin
					rem_p[c] = num_in[c];
					quo_p[c] = '0;
					neg_p[c] = neg_in[c];
				end
			end
		end else begin : g_next
			always_comb begin
				tag_p = tag_s[j];
				for (int c = 0; c < 3; c++) begin
					rem_p[c] = rem_s[j][c];
					quo_p[c] = quo_s[j][c];
					neg_p[c] = neg_s[j][c];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[j+1] <= '0;
			end else if (en) begin
				tag_s[j+1] <= tag_p;
			end
		end

		// Trial subtract of the shifted divisor.
		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					neg_s[j+1][c] <= neg_p[c];
					if (rem_p[c] >= dsh) begin
						rem_s[j+1][c] <= rem_p[c] - dsh;
						quo_s[j+1][c] <= {quo_p[c][QUO_W-2:0], 1'b1};
					end else begin
						rem_s[j+1][c] <= rem_p[c];
						quo_s[j+1][c] <= {quo_p[c][QUO_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign tag_out = tag_s[QUO_W];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quo_out[c] = quo_s[QUO_W][c];
			neg_out[c] = neg_s[QUO_W][c];
		end
	end

endmodule

`default_nettype wire

/* rtl/cubic_bezier_arc_tessellator_top.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier arc tessellator
// Takes an arc request and streams point_count samples of the cubic curve.
// ----------------------------------------------------------------------------
// Sequence per request: a control load (ABS, DIV3 and LOADC states), one sample
// per cycle while the output is not stalled, a wait until the last sample has
// freed the control points, then a return to idle to accept the next request.
// Reset: asynchronous, clears sequencer, valid bits and sets point_count 15.
`default_nettype none

module cubic_bezier_arc_tessellator_top
	import bzt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [6:0]   cfg_wdata,      // point_count
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// origin_x, origin_y, origin_z, dest_x, dest_y, dest_z
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// point_x, point_y, point_z, sample_index, two zero bits
	output logic [79:0]       m_tdata,
	output logic              m_tlast         // last_sample
);

	logic              en;
	point_t [3:0]      cp;
	tag_t              tag_s1, tag_s7, tag_d;
	logic [IDX_W-1:0]  u_s1;
	logic [CUBE_W-1:0] m3;
	logic              drain_done;
	logic [SUM_W-1:0]  num_s7 [3];
	logic              neg_s7 [3];
	logic [QUO_W-1:0]  quo_d [3];
	logic              neg_d [3];
	logic              out_valid_q;
	coord_t            res_c [3];
	point_t            pt_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;

	// The whole pipeline moves when the output word is free or taken.
	assign en = !out_valid_q || m_tready;

	bzt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.drain_done(drain_done), .cp(cp), .tag_s1(tag_s1), .u_s1(u_s1), .m3(m3)
	);

	bzt_eval u_eval (
		.clk(clk), .arst_n(arst_n), .en(en), .tag_s1(tag_s1), .u_s1(u_s1), .cp(cp),
		.m3(m3), .drain_done(drain_done), .tag_s7(tag_s7), .num_s7(num_s7),
		.neg_s7(neg_s7)
	);

	bzt_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .m3(m3), .tag_in(tag_s7),
		.num_in(num_s7), .neg_in(neg_s7), .tag_out(tag_d), .quo_out(quo_d),
		.neg_out(neg_d)
	);

	// Apply the sign and saturate the positive end.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (neg_d[c]) begin
				res_c[c] = -$signed(quo_d[c]);
			end else if (quo_d[c][QUO_W-1]) begin
				res_c[c] = {1'b0, {(COORD_W-1){1'b1}}};
			end else begin
				res_c[c] = $signed(quo_d[c]);
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tag_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_q.x <= res_c[0];
			pt_q.y <= res_c[1];
			pt_q.z <= res_c[2];
			idx_q  <= tag_d.idx;
			last_q <= tag_d.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, idx_q, pt_q};
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

/* tb/sv/cubic_bezier_arc_tessellator_checker.sv */
// ----------------------------------------------------------------------------
// Bezier arc sample checker
// Watches the request and sample streams, predicts every sample word of each
// accepted arc request and compares the words in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_arc_tessellator_checker
	import bzt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [6:0]   cfg_wdata,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [143:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [79:0]  m_tdata,
	input  wire logic         m_tlast,
	output int                fail_count,
	output int                pending,
	output int                samples_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
		logic [5:0]  idx;
		logic        last;
	} sample_t;

	sample_t     sample_q[$];
	logic [6:0]  count_reg;

	// Clamp to the signed coordinate range.
	function automatic longint clamp_coord(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// Nearest of n/3; ties cannot occur.
	function automatic longint third_near(longint n);
		if (n >= 0) return (n + 1) / 3;
		return -((-n + 1) / 3);
	endfunction

	// Nearest of num/den with ties away from zero.
	function automatic longint div_near(longint num, longint den);
		if (num >= 0) return (num * 2 + den) / (den * 2);
		return -((-num * 2 + den) / (den * 2));
	endfunction

	// Build the control points and queue every sample of one arc.
	task automatic predict_arc(logic [143:0] req);
		longint o[3], d[3], p[4][3];
		longint ymax, m, m3, u, w0, w1, w2, w3;
		int cnt;
		sample_t s;
		longint v[3];
		for (int c = 0; c < 3; c++) begin
			o[c] = longint'($signed(req[24*c +: 24]));
			d[c] = longint'($signed(req[72 + 24*c +: 24]));
			p[0][c] = o[c];
			p[3][c] = d[c];
		end
		ymax = (o[1] > d[1]) ? o[1] : d[1];
		p[1][0] = clamp_coord(third_near(2 * o[0] + d[0]));
		p[1][2] = clamp_coord(third_near(2 * o[2] + d[2]));
		p[2][0] = clamp_coord(third_near(o[0] + 2 * d[0]));
		p[2][2] = clamp_coord(third_near(o[2] + 2 * d[2]));
		p[1][1] = clamp_coord(ymax + (64'sd1 << (FRAC_BITS - 2)));
		p[2][1] = clamp_coord(ymax + (64'sd1 << (FRAC_BITS - 1)));
		cnt = count_reg;
		if (cnt < 2) cnt = 2;
		if (cnt > MAX_POINTS) cnt = MAX_POINTS;
		m = cnt - 1;
		m3 = m * m * m;
		for (int i = 0; i < cnt; i++) begin
			u = m - i;
			w0 = u * u * u;
			w1 = 3 * i * u * u;
			w2 = 3 * i * i * u;
			w3 = longint'(i) * i * i;
			for (int c = 0; c < 3; c++)
				v[c] = clamp_coord(div_near(w0 * p[0][c] + w1 * p[1][c]
					+ w2 * p[2][c] + w3 * p[3][c], m3));
			s.x = v[0][23:0];
			s.y = v[1][23:0];
			s.z = v[2][23:0];
			s.idx = i[5:0];
			s.last = (i == cnt - 1);
			sample_q = {sample_q, s};
		end
	endtask

	// Track configuration, predict on request words, check sample words.
	always @(posedge clk or negedge arst_n) begin
		sample_t e, a;
		if (!arst_n) begin
			count_reg = 7'd15;
			sample_q.delete();
			fail_count = 0;
			samples_seen = 0;
			pending = 0;
		end else begin
			if (cfg_we) count_reg = cfg_wdata;
			if (s_tvalid && s_tready) predict_arc(s_tdata);
			if (m_tvalid && m_tready) begin
				a.x = m_tdata[23:0];
				a.y = m_tdata[47:24];
				a.z = m_tdata[71:48];
				a.idx = m_tdata[77:72];
				a.last = m_tlast;
				samples_seen++;
				if (sample_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected sample word x=%h y=%h z=%h idx=%0d last=%b",
						$time, a.x, a.y, a.z, a.idx, a.last);
				end else begin
					e = sample_q.pop_front();
					if (e !== a) begin
						fail_count++;
						$display("%0t: sample mismatch expected x=%h y=%h z=%h idx=%0d last=%b",
							$time, e.x, e.y, e.z, e.idx, e.last);
						$display("%0t:                 actual   x=%h y=%h z=%h idx=%0d last=%b",
							$time, a.x, a.y, a.z, a.idx, a.last);
					end
				end
			end
			pending = sample_q.size();
		end
	end

endmodule

`default_nettype wire

/* tb/sv/cubic_bezier_arc_tessellator_top_tb.sv */
// ----------------------------------------------------------------------------
// Bezier arc tessellator testbench
// Drives directed and random arc requests under several sample counts and
// handshake idling patterns; the checker predicts and compares each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_arc_tessellator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 60;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [6:0]   cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [79:0]  m_tdata;
	logic         m_tlast;
	int           fail_count, pending, samples_seen;
	int           send_idle_pct = 0, recv_idle_pct = 0;
	int           arcs_sent = 0, idle_cycles = 0;
	logic [6:0]   counts[8] = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd127, 7'd65, 7'd5, 7'd9};

	always #2 clk = ~clk;

	cubic_bezier_arc_tessellator_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	cubic_bezier_arc_tessellator_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .fail_count(fail_count), .pending(pending),
		.samples_seen(samples_seen)
	);

	// Receiver stalls at random, changed at the falling edge.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Watchdog on cycles in which no word moves.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d samples outstanding", pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(5))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($urandom_range(2000)) - 24'd1000;
			default: return 24'($urandom);
		endcase
	endfunction

	// Send one arc request, with optional idle cycles before it. The valid
	// stays up after the accept until the next request or a drain; the block
	// is not ready again before then.
	task automatic send_arc(logic [143:0] req);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= req;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		arcs_sent++;
	endtask

	task automatic send_random_arc();
		send_arc({rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord()});
	endtask

	// Wait until all samples are back, then let the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(logic [6:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, the y bump saturating, and reset count of 15.
		send_arc('0);
		send_arc({6{24'h7fffff}});
		send_arc({6{24'h800000}});
		send_arc({24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000});
		send_arc({24'h7fffff, 24'h7ff000, 24'h800000, 24'h800000, 24'h000001, 24'h7fffff});
		send_arc({24'h555555, 24'haaaaaa, 24'h123456, 24'hfedcba, 24'h010000, 24'hff0000});
		// Count extremes and out-of-range counts.
		for (int k = 0; k < 6; k++) begin
			write_count(counts[k]);
			send_arc({6{24'h7fffff}});
			send_arc({24'h800000, 24'h400000, 24'h7fffff, 24'h000000, 24'h800000, 24'h3fffff});
			send_arc({24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555});
		end

		// Random phases: sender idles lightly, then heavily, then never.
		send_idle_pct = 11; recv_idle_pct = 55;
		write_count(7'd15);
		for (int k = 0; k < 140; k++) begin
			if (k == 70) drain();
			if (k % 35 == 0 && k > 0) write_count(counts[$urandom_range(7)] | 7'($urandom_range(1)));
			send_random_arc();
		end
		send_idle_pct = 55; recv_idle_pct = 11;
		write_count(7'($urandom_range(2, 20)));
		for (int k = 0; k < 140; k++) begin
			if (k % 35 == 0 && k > 0) write_count(7'($urandom_range(2, 20)));
			send_random_arc();
		end
		send_idle_pct = 0; recv_idle_pct = 0;
		write_count(7'd3);
		for (int k = 0; k < 130; k++) begin
			if (k == 65) write_count(7'd64);
			if (k == 70) write_count(7'($urandom_range(0, 127)));
			send_random_arc();
		end

		drain();
		$display("Covered %0d arc requests and %0d sample words over counts 0 to 127,",
			arcs_sent, samples_seen);
		$display("with coordinate extremes and three sender and receiver idling patterns.");
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
